/* design/m6502x_pkg.sv */
package m6502x_pkg;

	typedef struct packed {
		logic [5:0]  mode;
		logic [3:0]  addressing;
		logic [7:0]  operand;
		logic [15:0] base_address;
		logic [1:0]  index_select;
		logic [15:0] pc_after;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  acc_value;
		logic [7:0]  x_value;
		logic [7:0]  y_value;
		logic [7:0]  status_value;
		logic [15:0] effective_address;
		logic        write_enable;
		logic [7:0]  write_data;
		logic [15:0] next_pc;
		logic [2:0]  cycles;
		logic        last;
	} out_item_t;

	// operation classes decided by the front end
	typedef enum logic [2:0] {
		CL_DATA, CL_RMW, CL_BRANCH, CL_JMP, CL_JSR, CL_FLAG, CL_XFER, CL_NOP
	} op_class_t;

	// classified beat handed from front to back
	typedef struct packed {
		op_class_t   cls;
		logic [5:0]  mode;
		logic [3:0]  addressing;
		logic [7:0]  operand;
		logic [15:0] base_address;
		logic [1:0]  index_select;
		logic [15:0] pc_after;
		logic        memory;
		logic [15:0] target;
	} work_t;

	localparam logic [5:0] OP_AND = 6'd0, OP_ORA = 6'd1, OP_EOR = 6'd2,
		OP_LDA = 6'd3, OP_LDX = 6'd4, OP_LDY = 6'd5, OP_CMP = 6'd6, OP_CPX = 6'd7,
		OP_CPY = 6'd8, OP_BIT = 6'd9, OP_ASL = 6'd10, OP_LSR = 6'd11,
		OP_INC = 6'd12, OP_DEC = 6'd13, OP_BPL = 6'd14, OP_BCS = 6'd19,
		OP_BEQ = 6'd21,
		OP_JMP = 6'd22, OP_JSR = 6'd23, OP_CLC = 6'd24, OP_SEC = 6'd25,
		OP_CLI = 6'd26, OP_SEI = 6'd27, OP_CLV = 6'd28, OP_CLD = 6'd29,
		OP_SED = 6'd30, OP_TAX = 6'd31, OP_TXA = 6'd32, OP_DEX = 6'd33,
		OP_INX = 6'd34, OP_TAY = 6'd35, OP_TYA = 6'd36, OP_DEY = 6'd37,
		OP_INY = 6'd38;

	localparam logic [3:0] AM_IMPL = 4'd0, AM_ZP = 4'd2, AM_ZPI = 4'd3,
		AM_ABSI = 4'd5, AM_INDX = 4'd6, AM_INDY = 4'd7, AM_IND = 4'd8,
		AM_REL = 4'd9;

	localparam logic [1:0] IX_X = 2'd1, IX_Y = 2'd2;

	localparam logic [7:0] FLAG_C = 8'h01, FLAG_Z = 8'h02, FLAG_I = 8'h04,
		FLAG_D = 8'h08, FLAG_V = 8'h40, FLAG_N = 8'h80;
	localparam logic [7:0] FLAGS_RESET = 8'h24;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] STACK_PAGE_HI = 8'h01;
	localparam int QUEUE_DEPTH = 2;

	function automatic logic [2:0] data_cycles(input logic [3:0] a);
		case (a)
			4'd2: data_cycles = 3'd3;
			4'd3, 4'd4, 4'd5, 4'd8: data_cycles = 3'd4;
			4'd6: data_cycles = 3'd6;
			4'd7: data_cycles = 3'd5;
			default: data_cycles = 3'd2;
		endcase
	endfunction

	function automatic logic [2:0] rmw_cycles(input logic [3:0] a);
		case (a)
			4'd2: rmw_cycles = 3'd5;
			4'd3, 4'd4: rmw_cycles = 3'd6;
			4'd5, 4'd6, 4'd7, 4'd8: rmw_cycles = 3'd7;
			default: rmw_cycles = 3'd2;
		endcase
	endfunction

	function automatic logic [7:0] with_nz(input logic [7:0] f, input logic [7:0] v);
		with_nz = f & ~(FLAG_N | FLAG_Z);
		with_nz[7] = v[7];
		with_nz[1] = (v == 8'd0);
	endfunction

endpackage

/* design/m6502x_front.sv */
module m6502x_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  m6502x_pkg::in_item_t in_data,
	output logic                 wk_valid,
	input  logic                 wk_pop,
	output m6502x_pkg::work_t    wk_data
);

	m6502x_pkg::work_t cw;
	logic [3:0] adr;
	m6502x_pkg::work_t q_mem_q [m6502x_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// classify the incoming beat
	always_comb begin
		adr = (in_data.addressing > m6502x_pkg::AM_REL) ? m6502x_pkg::AM_IMPL
			: in_data.addressing;
		cw.mode = in_data.mode;
		cw.addressing = adr;
		cw.operand = in_data.operand;
		cw.base_address = in_data.base_address;
		cw.index_select = in_data.index_select;
		cw.pc_after = in_data.pc_after;
		cw.memory = (adr >= m6502x_pkg::AM_ZP) && (adr <= m6502x_pkg::AM_IND);
		cw.target = in_data.pc_after + {{8{in_data.operand[7]}}, in_data.operand};
		if (in_data.mode <= m6502x_pkg::OP_BIT) cw.cls = m6502x_pkg::CL_DATA;
		else if (in_data.mode <= m6502x_pkg::OP_DEC) cw.cls = m6502x_pkg::CL_RMW;
		else if (in_data.mode <= m6502x_pkg::OP_BEQ) cw.cls = m6502x_pkg::CL_BRANCH;
		else if (in_data.mode == m6502x_pkg::OP_JMP) cw.cls = m6502x_pkg::CL_JMP;
		else if (in_data.mode == m6502x_pkg::OP_JSR) cw.cls = m6502x_pkg::CL_JSR;
		else if (in_data.mode <= m6502x_pkg::OP_SED) cw.cls = m6502x_pkg::CL_FLAG;
		else if (in_data.mode <= m6502x_pkg::OP_INY) cw.cls = m6502x_pkg::CL_XFER;
		else cw.cls = m6502x_pkg::CL_NOP;
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign wk_valid = (count_q != 2'd0);
	assign wk_data = q_mem_q[rd_ptr_q];

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (wk_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(wk_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= cw;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue overfill");
	assert property (@(posedge clk) disable iff (!arst_n) wk_pop |-> wk_valid)
		else $error("pop of empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 && !push) |=> count_q == 2'd0)
		else $error("queue filled from nowhere");

endmodule

/* design/m6502x_back.sv */
module m6502x_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wk_valid,
	output logic                  wk_pop,
	input  m6502x_pkg::work_t     wk_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output m6502x_pkg::out_item_t out_data
);

	logic [7:0] a_q, x_q, y_q, p_q, sp_q;
	logic       second_q;
	logic [7:0] ret_lo_q;
	logic [15:0] jsr_pc_q;
	logic       ov_q;
	m6502x_pkg::out_item_t ob_q;

	logic [7:0] a_n, x_n, y_n, p_n, sp_n, idx, v, r, reg_c, diff;
	logic [15:0] ea, ret, npc;
	logic [2:0] cyc;
	logic we, page_cross, taken, set, lastb;
	logic [7:0] wd;
	logic [2:0] k;
	logic adv;
	m6502x_pkg::out_item_t res;

	// output register frees when taken
	assign adv = !ov_q || !out_stall;

	always_comb begin
		a_n = a_q; x_n = x_q; y_n = y_q; p_n = p_q; sp_n = sp_q;
		idx = (wk_data.index_select == m6502x_pkg::IX_X) ? x_q
			: (wk_data.index_select == m6502x_pkg::IX_Y) ? y_q : 8'd0;
		ea = 16'd0; we = 1'b0; wd = 8'd0; npc = wk_data.pc_after; cyc = 3'd2;
		lastb = 1'b1; page_cross = 1'b0; v = 8'd0; r = 8'd0; reg_c = 8'd0; diff = 8'd0;
		set = 1'b0; taken = 1'b0; k = 3'd0;
		ret = wk_data.pc_after - 16'd1;
		// effective address
		case (wk_data.addressing)
			m6502x_pkg::AM_ZP, m6502x_pkg::AM_ZPI:
				ea = {8'd0, wk_data.base_address[7:0] + idx};
			m6502x_pkg::AM_INDX: ea = wk_data.base_address;
			m6502x_pkg::AM_REL: ea = wk_data.target;
			default: if (wk_data.memory) ea = wk_data.base_address + {8'd0, idx};
		endcase
		if ((wk_data.addressing == m6502x_pkg::AM_ABSI ||
			wk_data.addressing == m6502x_pkg::AM_INDY) &&
			ea[15:8] != wk_data.base_address[15:8]) page_cross = 1'b1;
		// execute
		case (wk_data.cls)
			m6502x_pkg::CL_DATA: begin
				cyc = m6502x_pkg::data_cycles(wk_data.addressing) + 3'(page_cross);
				case (wk_data.mode)
					m6502x_pkg::OP_AND: begin a_n = a_q & wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, a_n); end
					m6502x_pkg::OP_ORA: begin a_n = a_q | wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, a_n); end
					m6502x_pkg::OP_EOR: begin a_n = a_q ^ wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, a_n); end
					m6502x_pkg::OP_LDA: begin a_n = wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, a_n); end
					m6502x_pkg::OP_LDX: begin x_n = wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, x_n); end
					m6502x_pkg::OP_LDY: begin y_n = wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, y_n); end
					m6502x_pkg::OP_BIT: begin
						p_n = (p_q & ~(m6502x_pkg::FLAG_N | m6502x_pkg::FLAG_V |
							m6502x_pkg::FLAG_Z)) | (wk_data.operand &
							(m6502x_pkg::FLAG_N | m6502x_pkg::FLAG_V));
						p_n[1] = ((a_q & wk_data.operand) == 8'd0);
					end
					default: begin
						reg_c = (wk_data.mode == m6502x_pkg::OP_CMP) ? a_q
							: (wk_data.mode == m6502x_pkg::OP_CPX) ? x_q : y_q;
						diff = reg_c - wk_data.operand;
						p_n = m6502x_pkg::with_nz(p_q, diff);
						p_n[0] = (reg_c >= wk_data.operand);
					end
				endcase
			end
			m6502x_pkg::CL_RMW: begin
				v = wk_data.memory ? wk_data.operand : a_q;
				if (wk_data.memory || wk_data.mode < m6502x_pkg::OP_INC) begin
					case (wk_data.mode)
						m6502x_pkg::OP_ASL: begin p_n[0] = v[7]; r = {v[6:0], 1'b0}; end
						m6502x_pkg::OP_LSR: begin p_n[0] = v[0]; r = {1'b0, v[7:1]}; end
						m6502x_pkg::OP_INC: r = v + 8'd1;
						default: r = v - 8'd1;
					endcase
					p_n = m6502x_pkg::with_nz(p_n, r);
					cyc = m6502x_pkg::rmw_cycles(wk_data.addressing);
					if (wk_data.memory) begin we = 1'b1; wd = r; end
					else a_n = r;
				end
			end
			m6502x_pkg::CL_BRANCH: begin
				k = 3'(wk_data.mode - m6502x_pkg::OP_BPL);
				case (k[2:1])
					2'd0: set = p_q[7];
					2'd1: set = p_q[6];
					2'd2: set = p_q[0];
					default: set = p_q[1];
				endcase
				taken = k[0] ? set : !set;
				if (taken) begin
					npc = wk_data.target;
					cyc = (wk_data.target[15:8] != wk_data.pc_after[15:8]) ? 3'd4 : 3'd3;
				end
			end
			m6502x_pkg::CL_JMP: begin
				npc = ea;
				cyc = (wk_data.addressing == m6502x_pkg::AM_IND) ? 3'd5 : 3'd3;
			end
			m6502x_pkg::CL_JSR: begin
				npc = ea; cyc = 3'd6; we = 1'b1; lastb = 1'b0;
				wd = ret[15:8];
				ea = {m6502x_pkg::STACK_PAGE_HI, sp_q};
				sp_n = sp_q - 8'd1;
			end
			m6502x_pkg::CL_FLAG: begin
				case (wk_data.mode)
					m6502x_pkg::OP_CLC: p_n = p_q & ~m6502x_pkg::FLAG_C;
					m6502x_pkg::OP_SEC: p_n = p_q | m6502x_pkg::FLAG_C;
					m6502x_pkg::OP_CLI: p_n = p_q & ~m6502x_pkg::FLAG_I;
					m6502x_pkg::OP_SEI: p_n = p_q | m6502x_pkg::FLAG_I;
					m6502x_pkg::OP_CLV: p_n = p_q & ~m6502x_pkg::FLAG_V;
					m6502x_pkg::OP_CLD: p_n = p_q & ~m6502x_pkg::FLAG_D;
					default: p_n = p_q | m6502x_pkg::FLAG_D;
				endcase
			end
			m6502x_pkg::CL_XFER: begin
				case (wk_data.mode)
					m6502x_pkg::OP_TAX: begin x_n = a_q; r = x_n; end
					m6502x_pkg::OP_TXA: begin a_n = x_q; r = a_n; end
					m6502x_pkg::OP_DEX: begin x_n = x_q - 8'd1; r = x_n; end
					m6502x_pkg::OP_INX: begin x_n = x_q + 8'd1; r = x_n; end
					m6502x_pkg::OP_TAY: begin y_n = a_q; r = y_n; end
					m6502x_pkg::OP_TYA: begin a_n = y_q; r = a_n; end
					m6502x_pkg::OP_DEY: begin y_n = y_q - 8'd1; r = y_n; end
					default: begin y_n = y_q + 8'd1; r = y_n; end
				endcase
				p_n = m6502x_pkg::with_nz(p_q, r);
			end
			default: ;
		endcase
		// second JSR push
		if (second_q) begin
			a_n = a_q; x_n = x_q; y_n = y_q; p_n = p_q;
			ea = {m6502x_pkg::STACK_PAGE_HI, sp_q};
			sp_n = sp_q - 8'd1;
			we = 1'b1; wd = ret_lo_q; npc = jsr_pc_q; cyc = 3'd6; lastb = 1'b1;
		end
		res.acc_value = a_n; res.x_value = x_n; res.y_value = y_n;
		res.status_value = p_n; res.effective_address = ea; res.write_enable = we;
		res.write_data = wd; res.next_pc = npc; res.cycles = cyc; res.last = lastb;
	end

	assign wk_pop = wk_valid && adv && (second_q || wk_data.cls != m6502x_pkg::CL_JSR)
		&& !second_q ? 1'b1 : (second_q && adv);
	assign out_valid = ov_q;
	assign out_data = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
			p_q <= m6502x_pkg::FLAGS_RESET; sp_q <= m6502x_pkg::SP_RESET;
			second_q <= 1'b0; ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= wk_valid || second_q;
			if (wk_valid || second_q) begin
				a_q <= a_n; x_q <= x_n; y_q <= y_n; p_q <= p_n; sp_q <= sp_n;
				second_q <= !second_q && wk_data.cls == m6502x_pkg::CL_JSR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ob_q <= res;
			if (!second_q) begin
				ret_lo_q <= ret[7:0];
				jsr_pc_q <= npc;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (out_valid && !out_data.last))
		else $error("second push without first");
	assert property (@(posedge clk) disable iff (!arst_n)
		(second_q && adv) |=> (out_data.last && out_data.write_enable))
		else $error("JSR low push missing");

endmodule

/* design/mos6502_execute_subset.sv */
// Channel | direction | beat payload            | handshake
// in      | input     | m6502x_pkg::in_item_t   | in_valid / in_stall
// out     | output    | m6502x_pkg::out_item_t  | out_valid / out_stall
// One instruction per cycle through the back end while out_stall is low; JSR
// holds it for both stack pushes. A beat is registered in the queue, then in
// the output register. The two-entry queue lets the input flow until it is
// full while a result waits under out_stall. arst_n clears registers to
// A=X=Y=0, P=0x24, SP=0xFD, and empties the queue and output register.
module mos6502_execute_subset (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  m6502x_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output m6502x_pkg::out_item_t out_data
);

	logic              wk_valid, wk_pop;
	m6502x_pkg::work_t wk_data;

	m6502x_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .wk_valid(wk_valid), .wk_pop(wk_pop), .wk_data(wk_data)
	);

	m6502x_back u_back (
		.clk(clk), .arst_n(arst_n), .wk_valid(wk_valid), .wk_pop(wk_pop),
		.wk_data(wk_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
